/* src/pfdt_pkg.sv */
// Package for the page framebuffer dirty tracker: sizes, codes and payload types.
package pfdt_pkg;

	localparam int COLUMNS          = 128;
	localparam int PAGES            = 8;
	localparam int BYTES_PER_RESULT = 8;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

	localparam logic [2:0] ACT_SET_PIXEL = 3'd0;
	localparam logic [2:0] ACT_WRITE_COL = 3'd1;
	localparam logic [2:0] ACT_FILL_RUN  = 3'd2;
	localparam logic [2:0] ACT_CLEAR     = 3'd3;
	localparam logic [2:0] ACT_REFRESH   = 3'd4;

	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_PAGE_COUNT    = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic       buffer_select;
		logic [6:0] column;
		logic [5:0] row;
		logic [3:0] bit_height;
		logic [7:0] run_width;
		logic [7:0] data_bits;
		logic       color;
		logic [2:0] refresh_page;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [2:0]  out_page;
		logic [6:0]  start_column;
		logic [3:0]  byte_count;
		logic [63:0] pixel_bytes;
		logic        last;
	} rsp_t;

endpackage

/* src/page_framebuffer_dirty_tracker.sv */
// Two page-addressed monochrome frame buffers with per-page dirty column tracking.
// The frame store is one single-port RAM with a registered read, and every byte access
// goes through it. After reset the block sweeps all 2048 bytes to zero before it takes
// its first command. Set pixel, a column write and a run read each column's byte and
// write it back, column by column, then mark the page dirty, repeat the columns and
// the mark on the next page when the bits cross into it, and emit one result.
// Clear sweeps the 1024 bytes of one buffer. Refresh reads each dirty byte and emits
// one result per group of up to 8 bytes. Rejected commands, a clean refresh, a
// zero-width run and bits that would cross past the last page go straight to the
// result state; a stalled result holds the block there until the transfer.
module page_framebuffer_dirty_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  pfdt_pkg::cmd_t       cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output pfdt_pkg::rsp_t       rsp,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int COL_W  = pfdt_pkg::COL_W;
	localparam int PAGE_W = pfdt_pkg::PAGE_W;
	localparam int ADDR_W = 1 + COL_W + PAGE_W;
	localparam int DEPTH  = 2 * pfdt_pkg::COLUMNS * pfdt_pkg::PAGES;
	localparam int DIDX_W = 1 + PAGE_W;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_WR, S_MARK, S_CLR, S_RF_RD, S_RF_CAP, S_EMIT
	} state_t;

	state_t state_q;

	logic [7:0] width_q;
	logic [6:0] height_q;
	logic [3:0] pages_q;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata;
	logic [ADDR_W-1:0] mem_addr;
	logic mem_we;
	logic [7:0] mem_wd;

	logic dvalid_q [2*pfdt_pkg::PAGES];
	logic [COL_W-1:0] dfirst_q [2*pfdt_pkg::PAGES];
	logic [COL_W-1:0] dlast_q [2*pfdt_pkg::PAGES];

	logic b_q, second_q, split_q, rclr_q;
	logic [COL_W-1:0] x0_q, x1_q, xc_q, rl_q;
	logic [PAGE_W-1:0] page_q, page_cur;
	logic [15:0] mask_q, pat_q;
	logic [ADDR_W-1:0] sw_q;
	logic [COL_W:0] rc_q;
	logic [3:0] rj_q, rn_q;
	logic [63:0] bytes_q;
	pfdt_pkg::rsp_t res_q;

	// effective sizes and command decode
	logic [8:0] ew;
	logic [7:0] eh;
	logic [4:0] np;
	logic bad_xy;
	logic [3:0] hh, hc;
	logic [7:0] dd;
	logic [8:0] wc;
	logic [8:0] lo_mask;
	logic [15:0] m16, p16;
	logic [5:0] y;
	logic [PAGE_W-1:0] ypage;
	logic [DIDX_W-1:0] rf_idx, cur_idx;
	logic [COL_W:0] diff;
	logic [3:0] n_next;
	logic [COL_W-1:0] col_rf;
	logic [7:0] merged;
	logic bad_cmd;
	logic [COL_W-1:0] x1_nxt;
	logic [PAGE_W-1:0] page_nxt;
	state_t idle_nxt;
	pfdt_pkg::rsp_t res_ok;

	always_comb begin
		ew = ({1'b0, width_q} > 9'(pfdt_pkg::COLUMNS)) ? 9'(pfdt_pkg::COLUMNS) : {1'b0, width_q};
		eh = ({1'b0, height_q} > 8'(pfdt_pkg::PAGES * 8)) ? 8'(pfdt_pkg::PAGES * 8)
			: {1'b0, height_q};
		np = ({1'b0, pages_q} > 5'(pfdt_pkg::PAGES)) ? 5'(pfdt_pkg::PAGES) : {1'b0, pages_q};
		y = cmd.row;
		ypage = PAGE_W'(y >> 3);
		bad_xy = ({2'b0, cmd.column} >= ew) || ({2'b0, y} >= eh);
		hh = (cmd.action == pfdt_pkg::ACT_SET_PIXEL) ? 4'd1 : cmd.bit_height;
		dd = (cmd.action == pfdt_pkg::ACT_SET_PIXEL) ? {7'd0, cmd.color} : cmd.data_bits;
		hc = (({2'b0, y} + 8'(hh)) > eh) ? 4'(eh - {2'b0, y}) : hh;
		wc = (({2'b0, cmd.column} + {1'b0, cmd.run_width}) > ew)
			? (ew - {2'b0, cmd.column}) : {1'b0, cmd.run_width};
		lo_mask = (9'd1 << hc) - 9'd1;
		m16 = {7'd0, lo_mask} << y[2:0];
		p16 = ({8'd0, dd} << y[2:0]) & m16;
		rf_idx = {cmd.buffer_select, PAGE_W'(cmd.refresh_page)};
		page_cur = PAGE_W'(page_q + PAGE_W'(second_q));
		cur_idx = {b_q, page_cur};
		diff = (COL_W+1)'({1'b0, rl_q} - rc_q + 1'b1);
		n_next = (diff > (COL_W+1)'(pfdt_pkg::BYTES_PER_RESULT))
			? 4'(pfdt_pkg::BYTES_PER_RESULT) : 4'(diff);
		col_rf = COL_W'(rc_q + (COL_W+1)'(rj_q));
		merged = second_q ? ((rdata & ~mask_q[15:8]) | pat_q[15:8])
			: ((rdata & ~mask_q[7:0]) | pat_q[7:0]);
	end

	// next state, status and first result of an accepted command
	always_comb begin
		bad_cmd = 1'b1;
		idle_nxt = S_EMIT;
		x1_nxt = cmd.column;
		page_nxt = ypage;
		case (cmd.action) inside
			pfdt_pkg::ACT_SET_PIXEL, pfdt_pkg::ACT_WRITE_COL, pfdt_pkg::ACT_FILL_RUN: begin
				bad_cmd = bad_xy || (cmd.action != pfdt_pkg::ACT_SET_PIXEL
					&& cmd.bit_height > 4'd8);
				if (cmd.action == pfdt_pkg::ACT_FILL_RUN) begin
					x1_nxt = COL_W'({2'b0, cmd.column} + wc - 9'd1);
				end
				if (!bad_cmd && !(cmd.action == pfdt_pkg::ACT_FILL_RUN && wc == 9'd0)
						&& !(m16[15:8] != 8'd0 && 32'(ypage) + 1 >= pfdt_pkg::PAGES)) begin
					idle_nxt = S_RD;
				end
			end
			pfdt_pkg::ACT_CLEAR: begin
				bad_cmd = 1'b0;
				idle_nxt = S_CLR;
			end
			pfdt_pkg::ACT_REFRESH: begin
				page_nxt = PAGE_W'(cmd.refresh_page);
				bad_cmd = ({2'b0, cmd.refresh_page} >= np);
				if (!bad_cmd && dvalid_q[rf_idx]) begin
					idle_nxt = S_RF_RD;
				end
			end
			default: ;
		endcase
		res_ok = '0;
		res_ok.status = bad_cmd;
		res_ok.out_page = (cmd.action == pfdt_pkg::ACT_REFRESH) ? cmd.refresh_page : 3'd0;
		res_ok.last = 1'b1;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = merged;
		case (state_q) inside
			S_INIT: begin
				mem_addr = sw_q;
				mem_we = 1'b1;
				mem_wd = '0;
			end
			S_CLR: begin
				mem_addr = {b_q, sw_q[ADDR_W-2:0]};
				mem_we = 1'b1;
				mem_wd = '0;
			end
			S_RF_RD, S_RF_CAP: mem_addr = {b_q, col_rf, page_q};
			S_WR: begin
				mem_addr = {b_q, xc_q, page_cur};
				mem_we = 1'b1;
			end
			default: mem_addr = {b_q, xc_q, page_cur};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		rdata <= mem[mem_addr];
	end

	assign cmd_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			width_q <= 8'd128;
			height_q <= 7'd64;
			pages_q <= 4'd8;
			sw_q <= '0;
			rsp_valid <= 1'b0;
			rclr_q <= 1'b0;
			for (int i = 0; i < 2*pfdt_pkg::PAGES; i++) begin
				dvalid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfdt_pkg::CFG_SCREEN_WIDTH:  width_q <= cfg_data;
					pfdt_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data[6:0];
					pfdt_pkg::CFG_PAGE_COUNT:    pages_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall && state_q != S_EMIT) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					sw_q <= ADDR_W'(sw_q + 1'b1);
					if (&sw_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						b_q <= cmd.buffer_select;
						res_q <= res_ok;
						second_q <= 1'b0;
						x0_q <= cmd.column;
						xc_q <= cmd.column;
						x1_q <= x1_nxt;
						page_q <= page_nxt;
						mask_q <= m16;
						pat_q <= p16;
						split_q <= (m16[15:8] != 8'd0);
						sw_q <= '0;
						state_q <= idle_nxt;
						if (idle_nxt == S_RF_RD) begin
							rc_q <= {1'b0, dfirst_q[rf_idx]};
							rl_q <= dlast_q[rf_idx];
							rj_q <= '0;
							bytes_q <= '0;
							rclr_q <= 1'b1;
						end
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (xc_q == x1_q) begin
						state_q <= S_MARK;
					end else begin
						xc_q <= COL_W'(xc_q + 1'b1);
						state_q <= S_RD;
					end
				end
				S_MARK: begin
					dvalid_q[cur_idx] <= 1'b1;
					if (!dvalid_q[cur_idx] || x0_q < dfirst_q[cur_idx]) begin
						dfirst_q[cur_idx] <= x0_q;
					end
					if (!dvalid_q[cur_idx] || x1_q > dlast_q[cur_idx]) begin
						dlast_q[cur_idx] <= x1_q;
					end
					if (split_q && !second_q) begin
						second_q <= 1'b1;
						xc_q <= x0_q;
						state_q <= S_RD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_CLR: begin
					sw_q <= ADDR_W'(sw_q + 1'b1);
					if (&sw_q[ADDR_W-2:0]) begin
						for (int p = 0; p < pfdt_pkg::PAGES; p++) begin
							if (p < int'(np)) begin
								dvalid_q[{b_q, PAGE_W'(p)}] <= (ew != 9'd0);
								dfirst_q[{b_q, PAGE_W'(p)}] <= '0;
								dlast_q[{b_q, PAGE_W'(p)}] <= COL_W'(ew - 9'd1);
							end
						end
						state_q <= S_EMIT;
					end
				end
				S_RF_RD: begin
					rn_q <= n_next;
					state_q <= S_RF_CAP;
				end
				S_RF_CAP: begin
					bytes_q[8*rj_q[2:0] +: 8] <= rdata;
					if (rj_q + 4'd1 == rn_q) begin
						res_q.status <= 1'b0;
						res_q.start_column <= rc_q[6:0];
						res_q.byte_count <= rn_q;
						res_q.pixel_bytes <= bytes_q | (64'(rdata) << (8*rj_q[2:0]));
						res_q.last <= (diff <= (COL_W+1)'(pfdt_pkg::BYTES_PER_RESULT));
						state_q <= S_EMIT;
					end else begin
						rj_q <= rj_q + 4'd1;
						state_q <= S_RF_RD;
					end
				end
				S_EMIT: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp <= res_q;
						rsp_valid <= 1'b1;
						if (!res_q.last) begin
							rc_q <= (COL_W+1)'(rc_q + (COL_W+1)'(pfdt_pkg::BYTES_PER_RESULT));
							rj_q <= '0;
							bytes_q <= '0;
							state_q <= S_RF_RD;
						end else begin
							if (rclr_q) begin
								dvalid_q[{b_q, page_q}] <= 1'b0;
								rclr_q <= 1'b0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
